// ===== design/otmt_pkg.sv =====
`default_nettype none

package otmt_pkg;

   // Radix-2^26 limb arithmetic for the 130-bit field
   localparam int WORD_W      = 64;
   localparam int BLOCK_W     = 2 * WORD_W;
   localparam int BLOCK_BYTES = 16;
   localparam int COUNT_W     = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int NUM_LIMBS   = 5;
   localparam int LIMB_IDX_W  = 3;
   localparam int LIMB_W      = 26;
   localparam int ACC_W       = LIMB_W + 1;
   localparam int RR_W        = LIMB_W + 3;
   localparam int PROD_W      = ACC_W + RR_W;
   localparam int T_W         = 60;
   localparam int CARRY_W     = T_W - LIMB_W;
   localparam int STEP_W      = 3;

   localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
   localparam logic [LIMB_W-1:0] CLAMP_R1  = 26'h3ffff03;
   localparam logic [LIMB_W-1:0] CLAMP_R2  = 26'h3ffc0ff;
   localparam logic [LIMB_W-1:0] CLAMP_R3  = 26'h3f03fff;
   localparam logic [LIMB_W-1:0] CLAMP_R4  = 26'h00fffff;

   localparam logic [LIMB_IDX_W-1:0] TOP_LIMB = LIMB_IDX_W'(NUM_LIMBS - 1);

   typedef logic [NUM_LIMBS-1:0][LIMB_W-1:0] limb_vec_type;
   typedef logic [NUM_LIMBS-1:0][ACC_W-1:0]  acc_vec_type;
   typedef logic [NUM_LIMBS-1:0][RR_W-1:0]   rr_vec_type;
   typedef logic [NUM_LIMBS-1:0][T_W-1:0]    sum_vec_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_R_LOW,
      CSR_KEY_R_HIGH,
      CSR_KEY_S_LOW,
      CSR_KEY_S_HIGH
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_MAC,
      ST_DRAIN,
      ST_CARRY,
      ST_FOLD,
      ST_TRIAL,
      ST_TAG
   } state_type;

   typedef struct packed {
      logic                  vld;
      logic                  first;
      logic [LIMB_IDX_W-1:0] dest;
   } mul_ctl_type;

   function automatic limb_vec_type split_limbs(input logic [BLOCK_W-1:0] blk,
                                                input logic full);
      limb_vec_type l;
      l[0] = blk[LIMB_W-1:0];
      l[1] = blk[2*LIMB_W-1:LIMB_W];
      l[2] = blk[3*LIMB_W-1:2*LIMB_W];
      l[3] = blk[4*LIMB_W-1:3*LIMB_W];
      l[4] = {1'b0, full, blk[BLOCK_W-1:4*LIMB_W]};
      return l;
   endfunction

   // Keep the valid bytes, place the 0x01 pad byte right after them,
   // and add 2^128 for a full block.
   function automatic limb_vec_type pad_block(input logic [WORD_W-1:0]  lo,
                                              input logic [WORD_W-1:0]  hi,
                                              input logic [COUNT_W-1:0] count);
      logic [BLOCK_W-1:0] blk;
      logic [BLOCK_W-1:0] padded;
      logic [COUNT_W-1:0] sat;
      logic               full;
      blk    = {hi, lo};
      sat    = (count > COUNT_W'(BLOCK_BYTES)) ? COUNT_W'(BLOCK_BYTES) : count;
      full   = (sat == COUNT_W'(BLOCK_BYTES));
      padded = '0;
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         if (COUNT_W'(b) < sat) begin
            padded[8*b +: 8] = blk[8*b +: 8];
         end else if (COUNT_W'(b) == sat) begin
            padded[8*b +: 8] = 8'h01;
         end
      end
      return split_limbs(padded, full);
   endfunction

   function automatic limb_vec_type clamp_r(input logic [WORD_W-1:0] lo,
                                            input logic [WORD_W-1:0] hi);
      limb_vec_type r;
      r    = split_limbs({hi, lo}, 1'b0);
      r[0] = r[0] & LIMB_MASK;
      r[1] = r[1] & CLAMP_R1;
      r[2] = r[2] & CLAMP_R2;
      r[3] = r[3] & CLAMP_R3;
      r[4] = r[4] & CLAMP_R4;
      return r;
   endfunction

   function automatic logic [RR_W-1:0] times5(input logic [LIMB_W-1:0] v);
      return (RR_W'(v) << 2) + RR_W'(v);
   endfunction

endpackage

`default_nettype wire

// ===== design/one_time_mac_tag_engine.sv =====
// Poly1305 one-time authenticator.
// Configuration: write r (two 64-bit words, clamped inside) and s (two
// 64-bit words) through csr_write_enable / csr_index / csr_write_data while
// the block is idle. Writes take effect at once; there is no read-back.
// Request channel: one item is one 16-byte little-endian message block with
// a byte count (0..16, larger counts act as 16) and a last flag. An item is
// taken when req_valid is high and req_stall is low.
// Result channel: one 128-bit tag per last item, held in an output register
// until taken (rsp_valid high and rsp_stall low). A stalled tag holds; the
// block still takes the next item and only waits at the end of the following
// last item if the old tag has not left yet.
// Sequence: one item is worked on at a time. A data item goes through 1 add,
// 25 partial products through the single shared 27x29 multiplier, 1 drain
// and 8 carry steps through the shared adder, then back to idle, where the
// next item is taken. A last item with data then goes through the final
// reduction (fold carry steps, trial subtraction, tag); an empty last item
// goes straight to the final reduction.
// An empty item without last is dropped in its accept cycle.
// Reset (synchronous): clears keys and accumulator, drops any pending tag.
`default_nettype none

module one_time_mac_tag_engine
   import otmt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_write_data,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [WORD_W-1:0]    req_block_low,
   input  wire logic [WORD_W-1:0]    req_block_high,
   input  wire logic [COUNT_W-1:0]   req_byte_count,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [WORD_W-1:0]         rsp_tag_low,
   output logic [WORD_W-1:0]         rsp_tag_high
);

   // carry pass after the multiply
   localparam logic [STEP_W-1:0] CY_T0   = 3'd0;
   localparam logic [STEP_W-1:0] CY_T1   = 3'd1;
   localparam logic [STEP_W-1:0] CY_T2   = 3'd2;
   localparam logic [STEP_W-1:0] CY_T3   = 3'd3;
   localparam logic [STEP_W-1:0] CY_T4   = 3'd4;
   localparam logic [STEP_W-1:0] CY_WRAP = 3'd5;
   localparam logic [STEP_W-1:0] CY_L1   = 3'd6;
   localparam logic [STEP_W-1:0] CY_L2   = 3'd7;
   // full carry of h before the final compare
   localparam logic [STEP_W-1:0] FD_L1   = 3'd0;
   localparam logic [STEP_W-1:0] FD_L2   = 3'd1;
   localparam logic [STEP_W-1:0] FD_L3   = 3'd2;
   localparam logic [STEP_W-1:0] FD_L4   = 3'd3;
   localparam logic [STEP_W-1:0] FD_WRAP = 3'd4;
   localparam logic [STEP_W-1:0] FD_FIX  = 3'd5;
   // trial subtraction g = h + 5 - 2^130
   localparam logic [STEP_W-1:0] TR_G0   = 3'd0;
   localparam logic [STEP_W-1:0] TR_G1   = 3'd1;
   localparam logic [STEP_W-1:0] TR_G2   = 3'd2;
   localparam logic [STEP_W-1:0] TR_G3   = 3'd3;
   localparam logic [STEP_W-1:0] TR_G4   = 3'd4;

   localparam logic [T_W-1:0] P_OFFSET = T_W'(5);

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff;
   logic [LIMB_IDX_W-1:0] j_ff, k_ff;

   logic [WORD_W-1:0]     key_r_low_ff, key_r_high_ff, key_s_low_ff, key_s_high_ff;

   limb_vec_type          m_ff;
   logic                  last_ff;
   acc_vec_type           acc_ff;
   sum_vec_type           t_ff;
   limb_vec_type          g_ff;
   logic                  keep_h_ff;
   logic [CARRY_W-1:0]    c_ff;

   logic                  rsp_valid_ff;
   logic [WORD_W-1:0]     rsp_tag_low_ff, rsp_tag_high_ff;

   logic                  req_accept, rsp_free, absorb_req;
   limb_vec_type          r_clamp;
   rr_vec_type            r_times5;
   logic [LIMB_IDX_W-1:0] rr_idx;
   logic [T_W-1:0]        c_times5;

   logic [ACC_W-1:0]      mul_h;
   logic [RR_W-1:0]       mul_r;
   mul_ctl_type           mul_issue, mul_done;
   logic [PROD_W-1:0]     mul_prod;

   logic [T_W-1:0]        cu_a, cu_b;
   logic [LIMB_W-1:0]     cu_lo;
   logic [CARRY_W-1:0]    cu_carry;
   logic                  acc_we, acc_wide, g_we;
   logic [LIMB_IDX_W-1:0] acc_sel;

   acc_vec_type           fin;
   logic [WORD_W-1:0]     pre_lo, pre_hi;
   logic [BLOCK_W-1:0]    tag_sum;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign absorb_req = (req_byte_count != '0);

   // clamped r and 5*r limbs feed the shared multiplier
   always_comb begin
      r_clamp = clamp_r(key_r_low_ff, key_r_high_ff);
      for (int i = 0; i < NUM_LIMBS; i++) begin
         r_times5[i] = times5(r_clamp[i]);
      end
   end

   // limb of r that pairs with h[j] for output limb k; wrapped terms use 5*r
   assign rr_idx   = (j_ff <= k_ff) ? (k_ff - j_ff)
                                    : (k_ff + LIMB_IDX_W'(NUM_LIMBS) - j_ff);
   assign c_times5 = (T_W'(c_ff) << 2) + T_W'(c_ff);

   otmt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .op_h    (mul_h),
      .op_r    (mul_r),
      .ctl_in  (mul_issue),
      .prod    (mul_prod),
      .ctl_out (mul_done)
   );

   otmt_carry u_carry (
      .op_a   (cu_a),
      .op_b   (cu_b),
      .sum_lo (cu_lo),
      .carry  (cu_carry)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (absorb_req) begin
                  state_in = ST_ABSORB;
               end else if (req_last) begin
                  state_in = ST_FOLD;
               end
            end
         end
         ST_ABSORB: state_in = ST_MAC;
         ST_MAC: begin
            if (j_ff == TOP_LIMB && k_ff == TOP_LIMB) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_CARRY;
         ST_CARRY: begin
            if (step_ff == CY_L2) begin
               state_in = last_ff ? ST_FOLD : ST_IDLE;
            end
         end
         ST_FOLD: begin
            if (step_ff == FD_FIX) begin
               state_in = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            if (step_ff == TR_G4) begin
               state_in = ST_TAG;
            end
         end
         ST_TAG: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs: handshake, multiplier issue, adder operands and writes
   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      mul_h           = acc_ff[j_ff];
      mul_r           = (j_ff <= k_ff) ? RR_W'(r_clamp[rr_idx]) : r_times5[rr_idx];
      mul_issue.vld   = (state_ff == ST_MAC);
      mul_issue.first = (j_ff == '0);
      mul_issue.dest  = k_ff;
      cu_a            = '0;
      cu_b            = '0;
      acc_we          = 1'b0;
      acc_wide        = 1'b0;
      acc_sel         = '0;
      g_we            = 1'b0;
      unique case (state_ff)
         ST_CARRY: begin
            acc_we = 1'b1;
            case (step_ff)
               CY_T0: begin
                  cu_a = t_ff[0];
                  acc_sel = 3'd0;
               end
               CY_T1: begin
                  cu_a = t_ff[1];
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd1;
               end
               CY_T2: begin
                  cu_a = t_ff[2];
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd2;
               end
               CY_T3: begin
                  cu_a = t_ff[3];
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd3;
               end
               CY_T4: begin
                  cu_a = t_ff[4];
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd4;
               end
               CY_WRAP: begin
                  cu_a = T_W'(acc_ff[0]);
                  cu_b = c_times5;
                  acc_sel = 3'd0;
               end
               CY_L1: begin
                  cu_a = T_W'(acc_ff[1]);
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd1;
               end
               default: begin
                  // limb 2 takes the last carry without masking
                  cu_a = T_W'(acc_ff[2]);
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd2;
                  acc_wide = 1'b1;
               end
            endcase
         end
         ST_FOLD: begin
            acc_we = 1'b1;
            case (step_ff)
               FD_L1: begin
                  cu_a = T_W'(acc_ff[1]);
                  acc_sel = 3'd1;
               end
               FD_L2: begin
                  cu_a = T_W'(acc_ff[2]);
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd2;
               end
               FD_L3: begin
                  cu_a = T_W'(acc_ff[3]);
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd3;
               end
               FD_L4: begin
                  cu_a = T_W'(acc_ff[4]);
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd4;
               end
               FD_WRAP: begin
                  cu_a = T_W'(acc_ff[0]);
                  cu_b = c_times5;
                  acc_sel = 3'd0;
               end
               FD_FIX: begin
                  cu_a = T_W'(acc_ff[1]);
                  cu_b = T_W'(c_ff);
                  acc_sel = 3'd1;
                  acc_wide = 1'b1;
               end
               default: begin
                  acc_we = 1'b0;
               end
            endcase
         end
         ST_TRIAL: begin
            g_we = 1'b1;
            case (step_ff)
               TR_G0: begin
                  cu_a = T_W'(acc_ff[0]);
                  cu_b = P_OFFSET;
               end
               TR_G1: begin
                  cu_a = T_W'(acc_ff[1]);
                  cu_b = T_W'(c_ff);
               end
               TR_G2: begin
                  cu_a = T_W'(acc_ff[2]);
                  cu_b = T_W'(c_ff);
               end
               TR_G3: begin
                  cu_a = T_W'(acc_ff[3]);
                  cu_b = T_W'(c_ff);
               end
               TR_G4: begin
                  cu_a = T_W'(acc_ff[4]);
                  cu_b = T_W'(c_ff);
               end
               default: begin
                  g_we = 1'b0;
               end
            endcase
         end
         default: begin
            acc_we = 1'b0;
         end
      endcase
   end

   // Pick h when h + 5 did not reach 2^130, else g, pack to 128 bits, add s.
   always_comb begin
      for (int i = 0; i < NUM_LIMBS; i++) begin
         fin[i] = keep_h_ff ? acc_ff[i] : {1'b0, g_ff[i]};
      end
      pre_lo = WORD_W'(fin[0])
             | (WORD_W'(fin[1]) << LIMB_W)
             | (WORD_W'(fin[2]) << (2 * LIMB_W));
      pre_hi = WORD_W'(fin[2] >> (WORD_W - 2 * LIMB_W))
             | (WORD_W'(fin[3]) << (3 * LIMB_W - WORD_W))
             | (WORD_W'(fin[4]) << (4 * LIMB_W - WORD_W));
      tag_sum = {pre_hi, pre_lo} + {key_s_high_ff, key_s_low_ff};
   end

   // control state, keys and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         key_r_low_ff  <= '0;
         key_r_high_ff <= '0;
         key_s_low_ff  <= '0;
         key_s_high_ff <= '0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         // restart the step count on every state change
         step_ff  <= (state_in != state_ff) ? '0 : step_ff + 1'b1;

         if (state_ff == ST_MAC) begin
            if (j_ff == TOP_LIMB) begin
               j_ff <= '0;
               k_ff <= k_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end else begin
            j_ff <= '0;
            k_ff <= '0;
         end

         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_KEY_R_LOW:  key_r_low_ff  <= csr_write_data;
               CSR_KEY_R_HIGH: key_r_high_ff <= csr_write_data;
               CSR_KEY_S_LOW:  key_s_low_ff  <= csr_write_data;
               CSR_KEY_S_HIGH: key_s_high_ff <= csr_write_data;
               default: ;
            endcase
         end

         if (state_ff == ST_ABSORB) begin
            for (int i = 0; i < NUM_LIMBS; i++) begin
               acc_ff[i] <= ACC_W'(acc_ff[i] + ACC_W'(m_ff[i]));
            end
         end else if (acc_we) begin
            acc_ff[acc_sel] <= acc_wide ? {cu_carry[0], cu_lo} : {1'b0, cu_lo};
         end else if (state_ff == ST_TAG && rsp_free) begin
            acc_ff <= '0;
         end

         if (state_ff == ST_TAG && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         m_ff    <= pad_block(req_block_low, req_block_high, req_byte_count);
         last_ff <= req_last;
      end
      if (mul_done.vld) begin
         t_ff[mul_done.dest] <= mul_done.first ? T_W'(mul_prod)
                                               : t_ff[mul_done.dest] + T_W'(mul_prod);
      end
      c_ff <= cu_carry;
      if (g_we) begin
         g_ff[step_ff] <= cu_lo;
      end
      if (state_ff == ST_TRIAL && step_ff == TR_G4) begin
         keep_h_ff <= (cu_carry == '0);
      end
      if (state_ff == ST_TAG && rsp_free) begin
         rsp_tag_low_ff  <= tag_sum[WORD_W-1:0];
         rsp_tag_high_ff <= tag_sum[BLOCK_W-1:WORD_W];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tag_low  = rsp_tag_low_ff;
   assign rsp_tag_high = rsp_tag_high_ff;

endmodule

`default_nettype wire

// ===== design/otmt_mul.sv =====
`default_nettype none

module otmt_mul
   import otmt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [ACC_W-1:0]  op_h,
   input  wire logic [RR_W-1:0]   op_r,
   input  wire mul_ctl_type       ctl_in,
   output logic [PROD_W-1:0]      prod,
   output mul_ctl_type            ctl_out
);

   logic [PROD_W-1:0] prod_ff;
   mul_ctl_type       ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // one partial product per cycle, registered before it is summed
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_h) * PROD_W'(op_r);
   end

   assign prod    = prod_ff;
   assign ctl_out = ctl_ff;

endmodule

`default_nettype wire

// ===== design/otmt_carry.sv =====
`default_nettype none

module otmt_carry
   import otmt_pkg::*;
(
   input  wire logic [T_W-1:0]     op_a,
   input  wire logic [T_W-1:0]     op_b,
   output logic [LIMB_W-1:0]       sum_lo,
   output logic [CARRY_W-1:0]      carry
);

   logic [T_W-1:0] total;

   // add, then split into a 26-bit limb and the carry out of it
   always_comb begin
      total  = op_a + op_b;
      sum_lo = total[LIMB_W-1:0];
      carry  = total[T_W-1:LIMB_W];
   end

endmodule

`default_nettype wire

// ===== design/otmt_check.sv =====
`default_nettype none

module otmt_check
   import otmt_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [COUNT_W-1:0] req_byte_count,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [WORD_W-1:0]  rsp_tag_low,
   input wire logic [WORD_W-1:0]  rsp_tag_high
);

   // reset drops any pending tag
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("tag still valid after reset");

   a_tag_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tag_low)
                                 && $stable(rsp_tag_high))
      else $error("stalled tag changed or vanished");

   // a data item keeps the block busy through add, multiply and carry pass
   a_busy_span: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_byte_count != '0) |-> ##35 req_stall)
      else $error("block ready again before the multiply finished");

   // a tag is only produced while the block is busy with a last item
   a_tag_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("tag appeared while the block was idle");

endmodule

bind one_time_mac_tag_engine otmt_check u_otmt_check (.*);

`default_nettype wire

// ===== tb/one_time_mac_tag_checker.sv =====
`timescale 1ns / 100ps

module one_time_mac_tag_checker
   import otmt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_write_data,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic [WORD_W-1:0]    req_block_low,
   input  wire logic [WORD_W-1:0]    req_block_high,
   input  wire logic [COUNT_W-1:0]   req_byte_count,
   input  wire logic                 req_last,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [WORD_W-1:0]    rsp_tag_low,
   input  wire logic [WORD_W-1:0]    rsp_tag_high,
   output int                        fail_count,
   output int                        tags_pending,
   output int                        items_seen,
   output int                        tags_checked
);

   localparam logic [63:0] M26     = 64'h3ffffff;
   localparam logic [63:0] R1_KEEP = 64'h3ffff03;
   localparam logic [63:0] R2_KEEP = 64'h3ffc0ff;
   localparam logic [63:0] R3_KEEP = 64'h3f03fff;
   localparam logic [63:0] R4_KEEP = 64'h00fffff;

   // five radix-2^26 limbs, each carried in a 64-bit lane
   typedef logic [4:0][63:0] limbs_type;

   typedef struct packed {
      logic [63:0] tag_low;
      logic [63:0] tag_high;
   } tag_pair_type;

   logic [63:0]  r_low, r_high, s_low, s_high;
   limbs_type    acc;
   tag_pair_type pending_tags[$];
   tag_pair_type want;
   logic [4:0]   eff_count;
   logic [127:0] sealed;

   function automatic limbs_type to_limbs(input logic [63:0] lo, input logic [63:0] hi);
      limbs_type l;
      l[0] = lo & M26;
      l[1] = (lo >> 26) & M26;
      l[2] = ((lo >> 52) | (hi << 12)) & M26;
      l[3] = (hi >> 14) & M26;
      l[4] = hi >> 40;
      return l;
   endfunction

   function automatic limbs_type times_r(input limbs_type h, input logic [63:0] klo,
                                         input logic [63:0] khi);
      limbs_type r, t, a;
      logic [63:0] c;
      r = to_limbs(klo, khi);
      r[1] = r[1] & R1_KEEP;
      r[2] = r[2] & R2_KEEP;
      r[3] = r[3] & R3_KEEP;
      r[4] = r[4] & R4_KEEP;
      t[0] = h[0]*r[0] + 64'd5*(h[1]*r[4] + h[2]*r[3] + h[3]*r[2] + h[4]*r[1]);
      t[1] = h[0]*r[1] + h[1]*r[0] + 64'd5*(h[2]*r[4] + h[3]*r[3] + h[4]*r[2]);
      t[2] = h[0]*r[2] + h[1]*r[1] + h[2]*r[0] + 64'd5*(h[3]*r[4] + h[4]*r[3]);
      t[3] = h[0]*r[3] + h[1]*r[2] + h[2]*r[1] + h[3]*r[0] + 64'd5*(h[4]*r[4]);
      t[4] = h[0]*r[4] + h[1]*r[3] + h[2]*r[2] + h[3]*r[1] + h[4]*r[0];
      c = t[0] >> 26; a[0] = t[0] & M26;
      t[1] = t[1] + c; c = t[1] >> 26; a[1] = t[1] & M26;
      t[2] = t[2] + c; c = t[2] >> 26; a[2] = t[2] & M26;
      t[3] = t[3] + c; c = t[3] >> 26; a[3] = t[3] & M26;
      t[4] = t[4] + c; c = t[4] >> 26; a[4] = t[4] & M26;
      a[0] = a[0] + c * 64'd5; c = a[0] >> 26; a[0] = a[0] & M26;
      a[1] = a[1] + c; c = a[1] >> 26; a[1] = a[1] & M26;
      a[2] = a[2] + c;
      return a;
   endfunction

   // add one padded block to h, then multiply by the clamped key
   function automatic limbs_type absorb_block(input limbs_type h, input logic [63:0] lo,
                                              input logic [63:0] hi, input logic [4:0] n,
                                              input logic [63:0] klo,
                                              input logic [63:0] khi);
      limbs_type m;
      int unsigned nb;
      nb = n;
      if (nb < 16) begin
         if (nb < 8) begin
            lo = lo & ((64'd1 << (8 * nb)) - 64'd1);
            lo = lo | (64'd1 << (8 * nb));
            hi = 64'd0;
         end else begin
            hi = hi & ((64'd1 << (8 * (nb - 8))) - 64'd1);
            hi = hi | (64'd1 << (8 * (nb - 8)));
         end
      end
      m = to_limbs(lo, hi);
      if (nb >= 16) m[4] = m[4] | (64'd1 << 24);
      for (int i = 0; i < 5; i++) h[i] = h[i] + m[i];
      return times_r(h, klo, khi);
   endfunction

   // full carry, conditional subtract of p, then add s mod 2^128
   function automatic logic [127:0] seal_tag(input limbs_type h, input logic [63:0] slo,
                                             input logic [63:0] shi);
      limbs_type g;
      logic [63:0] c, sel, lo, hi, sum;
      c = h[1] >> 26; h[1] = h[1] & M26;
      h[2] = h[2] + c; c = h[2] >> 26; h[2] = h[2] & M26;
      h[3] = h[3] + c; c = h[3] >> 26; h[3] = h[3] & M26;
      h[4] = h[4] + c; c = h[4] >> 26; h[4] = h[4] & M26;
      h[0] = h[0] + c * 64'd5; c = h[0] >> 26; h[0] = h[0] & M26;
      h[1] = h[1] + c;
      g[0] = h[0] + 64'd5; c = g[0] >> 26; g[0] = g[0] & M26;
      g[1] = h[1] + c; c = g[1] >> 26; g[1] = g[1] & M26;
      g[2] = h[2] + c; c = g[2] >> 26; g[2] = g[2] & M26;
      g[3] = h[3] + c; c = g[3] >> 26; g[3] = g[3] & M26;
      g[4] = h[4] + c - (64'd1 << 26);
      sel = 64'd0 - (g[4] >> 63);
      for (int i = 0; i < 5; i++) h[i] = (h[i] & sel) | (g[i] & ~sel & M26);
      lo  = h[0] | (h[1] << 26) | (h[2] << 52);
      hi  = (h[2] >> 12) | (h[3] << 14) | (h[4] << 40);
      sum = lo + slo;
      c   = (sum < lo) ? 64'd1 : 64'd0;
      return {hi + shi + c, sum};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         r_low        = '0;
         r_high       = '0;
         s_low        = '0;
         s_high       = '0;
         acc          = '0;
         pending_tags.delete();
         fail_count   = 0;
         items_seen   = 0;
         tags_checked = 0;
         tags_pending = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KEY_R_LOW:  r_low  = csr_write_data;
               CSR_KEY_R_HIGH: r_high = csr_write_data;
               CSR_KEY_S_LOW:  s_low  = csr_write_data;
               CSR_KEY_S_HIGH: s_high = csr_write_data;
               default: ;
            endcase
         end
         // retire the tag first: it always belongs to an older item
         if (rsp_valid && !rsp_stall) begin
            if (pending_tags.size() == 0) begin
               $error("tag with none pending: tag_low %h tag_high %h",
                      rsp_tag_low, rsp_tag_high);
               fail_count++;
            end else begin
               want = pending_tags.pop_front();
               if (rsp_tag_low !== want.tag_low) begin
                  $error("tag_low: expected %h, got %h", want.tag_low, rsp_tag_low);
                  fail_count++;
               end
               if (rsp_tag_high !== want.tag_high) begin
                  $error("tag_high: expected %h, got %h", want.tag_high, rsp_tag_high);
                  fail_count++;
               end
               tags_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            items_seen++;
            eff_count = (req_byte_count > 5'd16) ? 5'd16 : req_byte_count;
            if (eff_count != 5'd0)
               acc = absorb_block(acc, req_block_low, req_block_high, eff_count,
                                  r_low, r_high);
            if (req_last) begin
               sealed = seal_tag(acc, s_low, s_high);
               want.tag_low  = sealed[63:0];
               want.tag_high = sealed[127:64];
               pending_tags.push_back(want);
               acc = '0;
            end
         end
         tags_pending = pending_tags.size();
      end
   end

endmodule

// ===== tb/tb_one_time_mac_tag_engine.sv =====
`timescale 1ns / 100ps

module tb_one_time_mac_tag_engine;
   import otmt_pkg::*;

   // cycles with no accept of any kind before the run is declared hung;
   // the worst legal quiet stretch is the long hold-off plus one last item
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLDOFF_LEN  = 600;
   localparam int PHASE_ITEMS  = 286;
   localparam int SETTLE_WAIT  = 64;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [WORD_W-1:0]    csr_write_data   = '0;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [WORD_W-1:0]    req_block_low    = '0;
   logic [WORD_W-1:0]    req_block_high   = '0;
   logic [COUNT_W-1:0]   req_byte_count   = '0;
   logic                 req_last         = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [WORD_W-1:0]    rsp_tag_low;
   logic [WORD_W-1:0]    rsp_tag_high;

   int fail_count, tags_pending, items_seen, tags_checked;

   // idle and stall percentages for the sender and the receiver process
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int holdoff_len        = 0;
   int quiet_cycles       = 0;
   int key_settings       = 0;

   // start low so the first rising edge comes after every process is waiting
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   one_time_mac_tag_engine u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_block_low    (req_block_low),
      .req_block_high   (req_block_high),
      .req_byte_count   (req_byte_count),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tag_low      (rsp_tag_low),
      .rsp_tag_high     (rsp_tag_high)
   );

   one_time_mac_tag_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_block_low    (req_block_low),
      .req_block_high   (req_block_high),
      .req_byte_count   (req_byte_count),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tag_low      (rsp_tag_low),
      .rsp_tag_high     (rsp_tag_high),
      .fail_count       (fail_count),
      .tags_pending     (tags_pending),
      .items_seen       (items_seen),
      .tags_checked     (tags_checked)
   );

   // Receiver: stall at random, or hold off for a long counted stretch
   // when the stimulus asks for one.
   initial begin : receiver
      int n;
      forever begin
         @(negedge clock);
         if (holdoff_len != 0) begin
            n = holdoff_len;
            holdoff_len = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
         end
      end
   end

   // Watchdog: count cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && !req_stall) ||
          (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no progress for %0d cycles, %0d tags still due",
                  QUIET_LIMIT, tags_pending);
         $display("one_time_mac_tag_engine regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mostly random words, with all-zero and all-one words mixed in.
   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Write one key register; the caller guarantees the engine is idle.
   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_keys(input logic [63:0] rl, input logic [63:0] rh,
                            input logic [63:0] sl, input logic [63:0] sh);
      write_reg(CSR_KEY_R_LOW,  rl);
      write_reg(CSR_KEY_R_HIGH, rh);
      write_reg(CSR_KEY_S_LOW,  sl);
      write_reg(CSR_KEY_S_HIGH, sh);
      key_settings++;
   endtask

   // Offer one block item, idling first at the sender's rate, and hold
   // the payload until the engine takes it. Returns at the accepting edge.
   task automatic offer_item(input logic [63:0] lo, input logic [63:0] hi,
                             input int cnt, input bit fin);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_block_low  <= lo;
      req_block_high <= hi;
      req_byte_count <= COUNT_W'(cnt);
      req_last       <= fin;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drop valid and wait until every tag owed has been taken.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (tags_pending == 0);
   endtask

   // Drain, then give a non-last block still in the multiplier time to
   // finish before any key register moves.
   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Mostly whole messages (full blocks then a final block of any length),
   // the rest loose items of any count and last flag.
   task automatic random_traffic(input int quota, input int pause_at, input int hold_at);
      int  sent;
      int  k;
      int  cnt;
      bit  fin;
      bit  paused;
      bit  held;
      sent   = 0;
      paused = 1'b0;
      held   = 1'b0;
      while (sent < quota) begin
         if (pause_at >= 0 && !paused && sent >= pause_at) begin
            paused = 1'b1;
            hold_until_drained();
         end
         if (hold_at >= 0 && !held && sent >= hold_at) begin
            held = 1'b1;
            holdoff_len = HOLDOFF_LEN;
         end
         if ($urandom_range(0, 99) < 80) begin
            k = $urandom_range(0, 3);
            repeat (k) offer_item(rand_word(), rand_word(), 16, 1'b0);
            offer_item(rand_word(), rand_word(), $urandom_range(0, 16), 1'b1);
            sent += k + 1;
         end else begin
            cnt = $urandom_range(0, 31);
            fin = $urandom_range(0, 1);
            offer_item(rand_word(), rand_word(), cnt, fin);
            // empty non-last items are dropped by the engine; skip them
            if (cnt != 0 || fin) sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // r = 1 makes h easy to steer: two all-one full blocks leave h just
      // above p, so the final subtract of p must kick in. s all ones
      // exercises the carry out of the low tag word.
      load_keys(64'd1, 64'd0, '1, '1);
      offer_item('1, '1, 16, 1'b0);
      offer_item('1, '1, 16, 1'b1);
      offer_item('0, '0, 0, 1'b1);          // empty last: tag is s alone
      offer_item('1, '1, 0, 1'b0);          // empty, no last: ignored
      offer_item('1, '1, 31, 1'b1);         // count saturates to a full block
      offer_item('1, '1, 1, 1'b1);          // bytes past the count are dropped
      offer_item('1, '1, 7, 1'b1);
      offer_item('1, '1, 8, 1'b1);
      offer_item('1, '1, 9, 1'b1);
      offer_item('1, '1, 15, 1'b1);
      offer_item('1, '1, 5, 1'b0);          // short block absorbed without a tag
      offer_item('0, '0, 16, 1'b1);
      offer_item('0, '0, 16, 1'b1);
      settle();

      // widest clamped r, zero s
      load_keys('1, '1, '0, '0);
      offer_item('1, '1, 16, 1'b0);
      offer_item('1, '1, 17, 1'b0);
      offer_item('1, '1, 16, 1'b1);
      offer_item(64'ha5a5_5a5a_0f0f_f0f0, '1, 3, 1'b1);
      offer_item('0, '1, 12, 1'b1);
      settle();

      // random phases, each under its own keys; the last two share one idling mix
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            3: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
            default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
         endcase
         case (ph)
            3:       load_keys('1, '1, rand_word(), rand_word());
            4:       load_keys('0, '0, '0, '0);
            default: load_keys(rand_word(), rand_word(), rand_word(), rand_word());
         endcase
         random_traffic(PHASE_ITEMS, (ph == 1) ? PHASE_ITEMS / 2 : -1,
                        (ph == 2) ? PHASE_ITEMS / 2 : -1);
         settle();
      end

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (100) @(posedge clock);

      $display("covered %0d block items and %0d tags under %0d key settings",
               items_seen, tags_checked, key_settings);
      $display("traffic mixes: free running, sender gaps, receiver stalls with a hold-off, both");
      if (fail_count == 0 && tags_pending == 0) begin
         $display("one_time_mac_tag_engine regression: pass");
      end else begin
         $display("one_time_mac_tag_engine regression: fail");
      end
      $finish;
   end

endmodule
